@@ rtl/acbd_pkg.sv @@
// acbd_pkg: shared types, constants and the distance-to-level function for the
// ambient class box distance level block. No dependencies.
`timescale 1ns / 1ps

package acbd_pkg;

  localparam int NumClasses = 4;
  localparam int CoordW     = 18;
  localparam int InCoordW   = 17;
  localparam int ClassW     = 2;
  localparam int DistW      = 16;
  localparam int LevelW     = 8;
  localparam int OutFields  = 4;
  localparam int GapW       = CoordW + 1;

  localparam int FarDist   = 65535;
  localparam int NearLimit = 100;
  localparam int FadeSpan  = 500;
  localparam int FullLevel = 255;

  // floor(n * 255 / 500) == (n * FadeMul) >> FadeShift for n <= 400
  localparam int FadeShift = 16;
  localparam int FadeMul   = 33424;
  localparam int SpanW     = 9;
  localparam int ProdW     = SpanW + FadeShift;

  typedef enum logic [1:0] {
    OP_LEAF_MIN = 2'd0,
    OP_LEAF_MAX = 2'd1,
    OP_VERTEX   = 2'd2,
    OP_FINISH   = 2'd3
  } op_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [GapW-1:0]   gap_t;
  typedef logic [DistW-1:0]         dist_t;
  typedef logic [LevelW-1:0]        level_t;

  typedef struct packed {
    logic              valid;
    logic [ClassW-1:0] cls;
    dist_t             distance;
  } close_t;

  function automatic level_t level_of(dist_t d);
    logic [SpanW-1:0] span;
    logic [ProdW-1:0] prod;
    level_t           lvl;
    span = '0;
    prod = '0;
    if (d < DistW'(NearLimit)) begin
      lvl = LevelW'(FullLevel);
    end else if (d >= DistW'(FadeSpan)) begin
      lvl = '0;
    end else begin
      span = SpanW'(DistW'(FadeSpan) - d);
      prod = ProdW'(span) * ProdW'(FadeMul);
      lvl  = prod[FadeShift +: LevelW];
    end
    return lvl;
  endfunction

endpackage

@@ rtl/ambient_class_box_distance_level.sv @@
// ambient_class_box_distance_level: top level with input register, per-class
// nearest distances and the level output register. Depends on acbd_pkg, acbd_box.
`timescale 1ns / 1ps

// One item per clock while the input is not stalled. A transfer lands in the
// input register, and from there its update runs through the box logic into
// the state registers. A finish item writes the levels of the four class
// distances into the output register. Input stall rises only when a finish
// waits in the input register while a previous result is still held with
// out_stall_i high. Corner, vertex and finish items otherwise flow at full
// rate. After reset the leaf corners are zero, the surface box is empty and
// all class distances read 65535 (level 0).
module ambient_class_box_distance_level (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      opcode_i,
  input  logic signed [16:0]              coord_x_i,
  input  logic signed [16:0]              coord_y_i,
  input  logic signed [16:0]              coord_z_i,
  input  logic [acbd_pkg::ClassW-1:0]     ambient_class_i,
  input  logic                            last_vertex_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output acbd_pkg::level_t                level_sky_o,
  output acbd_pkg::level_t                level_water_o,
  output acbd_pkg::level_t                level_slime_o,
  output acbd_pkg::level_t                level_lava_o
);
  import acbd_pkg::*;

  logic              v0_q;
  op_e               op0_q;
  coord_t            coord0_q [3];
  logic [ClassW-1:0] cls0_q;
  logic              last0_q;

  dist_t  nearest_q [NumClasses];
  dist_t  nearest_d [NumClasses];
  logic   out_valid_q;
  level_t lvl_q [OutFields];
  level_t lvl_d [OutFields];

  logic   accept;
  logic   out_free;
  logic   adv;
  logic   adv_finish;
  close_t close;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = v0_q && ((op0_q != OP_FINISH) || out_free);
  assign adv_finish = adv && (op0_q == OP_FINISH);
  assign in_stall_o = v0_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (accept) begin
      v0_q <= 1'b1;
    end else if (adv) begin
      v0_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op0_q       <= op_e'(opcode_i);
      coord0_q[0] <= CoordW'(coord_x_i);
      coord0_q[1] <= CoordW'(coord_y_i);
      coord0_q[2] <= CoordW'(coord_z_i);
      cls0_q      <= ambient_class_i;
      last0_q     <= last_vertex_i;
    end
  end

  acbd_box u_box (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (adv),
    .op_i    (op0_q),
    .coord_i (coord0_q),
    .class_i (cls0_q),
    .last_i  (last0_q),
    .close_o (close)
  );

  always_comb begin
    for (int c = 0; c < NumClasses; c++) begin
      nearest_d[c] = nearest_q[c];
      if (adv && (op0_q == OP_LEAF_MIN)) begin
        nearest_d[c] = DistW'(FarDist);
      end else if (close.valid && (close.cls == ClassW'(c)) &&
                   (close.distance < nearest_q[c])) begin
        nearest_d[c] = close.distance;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumClasses; c++) begin
        nearest_q[c] <= DistW'(FarDist);
      end
    end else begin
      for (int c = 0; c < NumClasses; c++) begin
        nearest_q[c] <= nearest_d[c];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < OutFields; i++) begin
      lvl_d[i] = '0;
      if (i < NumClasses) begin
        lvl_d[i] = level_of(nearest_q[ClassW'(i)]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_finish) begin
      for (int i = 0; i < OutFields; i++) begin
        lvl_q[i] <= lvl_d[i];
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign level_sky_o   = lvl_q[0];
  assign level_water_o = lvl_q[1];
  assign level_slime_o = lvl_q[2];
  assign level_lava_o  = lvl_q[3];

  // finish never overwrites a result that is still held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_finish |-> !(out_valid_q && out_stall_i))
    else $error("finish advanced over a held result");

  // stall only with an item waiting
  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v0_q)
    else $error("input stalled with empty input register");

  // a new result only follows a finish
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv_finish))
    else $error("result appeared without a finish");

  // leaf min corner clears the class distances; checked on class 0
  a_leaf_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (op0_q == OP_LEAF_MIN)) |=> (nearest_q[0] == DistW'(FarDist)))
    else $error("class distance not cleared on leaf start");

endmodule

@@ rtl/acbd_box.sv @@
// acbd_box: leaf box corners and the running surface box; reports the clamped
// box gap when a surface closes. Depends on acbd_pkg.
`timescale 1ns / 1ps

module acbd_box (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  acbd_pkg::op_e                 op_i,
  input  acbd_pkg::coord_t              coord_i [3],
  input  logic [acbd_pkg::ClassW-1:0]   class_i,
  input  logic                          last_i,
  output acbd_pkg::close_t              close_o
);
  import acbd_pkg::*;

  localparam coord_t SurfLoInit = coord_t'(FarDist);
  localparam coord_t SurfHiInit = coord_t'(-FarDist);

  coord_t leaf_lo_q [3];
  coord_t leaf_hi_q [3];
  coord_t surf_lo_q [3];
  coord_t surf_hi_q [3];
  coord_t surf_lo_d [3];
  coord_t surf_hi_d [3];
  coord_t lo_new    [3];
  coord_t hi_new    [3];
  gap_t   gap       [3];
  gap_t   far;
  logic   closing;

  assign closing = step_i && (op_i == OP_VERTEX) && last_i;

  always_comb begin
    far = '0;
    for (int a = 0; a < 3; a++) begin
      lo_new[a] = (coord_i[a] < surf_lo_q[a]) ? coord_i[a] : surf_lo_q[a];
      hi_new[a] = (coord_i[a] > surf_hi_q[a]) ? coord_i[a] : surf_hi_q[a];
      if (lo_new[a] > leaf_hi_q[a]) begin
        gap[a] = GapW'(lo_new[a]) - GapW'(leaf_hi_q[a]);
      end else if (hi_new[a] < leaf_lo_q[a]) begin
        gap[a] = GapW'(leaf_lo_q[a]) - GapW'(hi_new[a]);
      end else begin
        gap[a] = '0;
      end
      if (gap[a] > far) begin
        far = gap[a];
      end
    end
  end

  always_comb begin
    close_o.valid    = closing;
    close_o.cls      = class_i;
    close_o.distance = (far > GapW'(FarDist)) ? DistW'(FarDist) : far[DistW-1:0];
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      surf_lo_d[a] = surf_lo_q[a];
      surf_hi_d[a] = surf_hi_q[a];
      if (step_i && (op_i == OP_VERTEX)) begin
        surf_lo_d[a] = last_i ? SurfLoInit : lo_new[a];
        surf_hi_d[a] = last_i ? SurfHiInit : hi_new[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        leaf_lo_q[a] <= '0;
        leaf_hi_q[a] <= '0;
        surf_lo_q[a] <= SurfLoInit;
        surf_hi_q[a] <= SurfHiInit;
      end
    end else begin
      for (int a = 0; a < 3; a++) begin
        surf_lo_q[a] <= surf_lo_d[a];
        surf_hi_q[a] <= surf_hi_d[a];
        if (step_i && (op_i == OP_LEAF_MIN)) begin
          leaf_lo_q[a] <= coord_i[a];
        end
        if (step_i && (op_i == OP_LEAF_MAX)) begin
          leaf_hi_q[a] <= coord_i[a];
        end
      end
    end
  end

endmodule
